FILE: design/pwi_pkg.sv
// Shared types and constants for the windowed-integral PID controller.
`timescale 1ns / 1ps

package pwi_pkg;

	localparam int DATA_W    = 32;
	localparam int LIM_W     = 31;
	localparam int DT_W      = 16;
	localparam int ERR_W     = 33;
	localparam int DIFF_W    = 34;
	localparam int MAG_W     = 33;
	localparam int PROD_W    = 65;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic [LIM_W-1:0]         LIM_MAX = 31'h7fff_ffff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_FEED_FWD,
		REG_OUT_UPPER,
		REG_OUT_LOWER,
		REG_INT_LIMIT,
		REG_INT_WINDOW
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic signed [DATA_W-1:0] feed_forward;
		logic signed [DATA_W-1:0] output_upper;
		logic signed [DATA_W-1:0] output_lower;
		logic [LIM_W-1:0]         integral_limit;
		logic [LIM_W-1:0]         integral_window;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_I,
		ST_ACC_I,
		ST_DIV_WAIT,
		ST_DERIV,
		ST_MUL_D,
		ST_ACC_D,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_P,
		MUL_I,
		MUL_D
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     update;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_en;
		logic     deriv_cap;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} status_t;

endpackage

FILE: design/pwi_if.sv
// Handshake channel interfaces: request, response and register write.
`timescale 1ns / 1ps

interface pwi_req_if;
	logic                                valid;
	logic                                ready;
	logic signed [pwi_pkg::DATA_W-1:0]   measurement;
	logic signed [pwi_pkg::DATA_W-1:0]   setpoint;
	logic [pwi_pkg::DT_W-1:0]            elapsed_ms;
	logic                                settled;

	modport source (output valid, measurement, setpoint, elapsed_ms, settled, input ready);
	modport sink (input valid, measurement, setpoint, elapsed_ms, settled, output ready);
endinterface

interface pwi_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [pwi_pkg::DATA_W-1:0] drive;
	logic                              clamped;

	modport source (output valid, drive, clamped, input ready);
	modport sink (input valid, drive, clamped, output ready);
endinterface

interface pwi_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pwi_pkg::CFG_IDX_W-1:0]    index;
	logic [pwi_pkg::DATA_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pwi_regs.sv
// Configuration register file written through the register channel.
`timescale 1ns / 1ps

module pwi_regs (
	input  logic          clk,
	input  logic          arst_n,
	pwi_cfg_if.sink       cfg,
	output pwi_pkg::cfg_t regs
);

	pwi_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_p          <= '0;
			regs_q.gain_i          <= '0;
			regs_q.gain_d          <= '0;
			regs_q.feed_forward    <= '0;
			regs_q.output_upper    <= pwi_pkg::S32_MAX;
			regs_q.output_lower    <= pwi_pkg::S32_MIN;
			regs_q.integral_limit  <= pwi_pkg::LIM_MAX;
			regs_q.integral_window <= pwi_pkg::LIM_MAX;
		end else if (cfg.valid && cfg.ready) begin
			case (pwi_pkg::reg_idx_t'(cfg.index))
				pwi_pkg::REG_GAIN_P:     regs_q.gain_p <= $signed(cfg.data);
				pwi_pkg::REG_GAIN_I:     regs_q.gain_i <= $signed(cfg.data);
				pwi_pkg::REG_GAIN_D:     regs_q.gain_d <= $signed(cfg.data);
				pwi_pkg::REG_FEED_FWD:   regs_q.feed_forward <= $signed(cfg.data);
				pwi_pkg::REG_OUT_UPPER:  regs_q.output_upper <= $signed(cfg.data);
				pwi_pkg::REG_OUT_LOWER:  regs_q.output_lower <= $signed(cfg.data);
				pwi_pkg::REG_INT_LIMIT:  regs_q.integral_limit <= cfg.data[pwi_pkg::LIM_W-1:0];
				pwi_pkg::REG_INT_WINDOW: regs_q.integral_window <= cfg.data[pwi_pkg::LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: design/pwi_div.sv
// Restoring serial divider, one quotient bit per cycle, for the derivative term.
`timescale 1ns / 1ps

module pwi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pwi_pkg::MAG_W-1:0]  dividend,
	input  logic [pwi_pkg::DT_W-1:0]   divisor,
	output logic                       busy,
	output logic [pwi_pkg::MAG_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(pwi_pkg::MAG_W);

	logic [CNT_W-1:0]            count_q;
	logic                        busy_q;
	logic [pwi_pkg::DT_W-1:0]    rem_q;
	logic [pwi_pkg::MAG_W-1:0]   quo_q;
	logic [pwi_pkg::DT_W:0]      trial;
	logic [pwi_pkg::DT_W:0]      trial_sub;
	logic                        fits;

	assign trial     = {rem_q, quo_q[pwi_pkg::MAG_W-1]};
	assign trial_sub = trial - {1'b0, divisor};
	assign fits      = trial >= {1'b0, divisor};
	assign busy      = busy_q;
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			count_q <= '0;
		end else if (busy_q) begin
			if (count_q == CNT_W'(pwi_pkg::MAG_W - 1)) begin
				busy_q <= 1'b0;
			end
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[pwi_pkg::DT_W-1:0] : trial[pwi_pkg::DT_W-1:0];
			quo_q <= {quo_q[pwi_pkg::MAG_W-2:0], fits};
		end
	end

endmodule

FILE: design/pwi_dpath.sv
// Datapath: error, integral, derivative, shared multiplier, accumulator, output clamp.
`timescale 1ns / 1ps

module pwi_dpath #(
	parameter int FRAC_BITS      = 16,
	parameter bit RESET_ON_CROSS = 1'b1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pwi_pkg::cfg_t                     regs,
	input  pwi_pkg::cmd_t                     cmd,
	output pwi_pkg::status_t                  status,
	input  logic signed [pwi_pkg::DATA_W-1:0] measurement,
	input  logic signed [pwi_pkg::DATA_W-1:0] setpoint,
	input  logic [pwi_pkg::DT_W-1:0]          elapsed_ms,
	input  logic                              settled,
	output logic signed [pwi_pkg::DATA_W-1:0] drive,
	output logic                              clamped
);

	localparam int ACC_W = pwi_pkg::PROD_W + 2 - FRAC_BITS;

	logic signed [pwi_pkg::ERR_W-1:0]  err_q;
	logic signed [pwi_pkg::ERR_W-1:0]  last_err_q;
	logic signed [pwi_pkg::DATA_W-1:0] integ_q;
	logic [pwi_pkg::DT_W-1:0]          dt_q;
	logic                              neg_q;
	logic signed [pwi_pkg::DATA_W-1:0] deriv_q;
	logic signed [pwi_pkg::PROD_W-1:0] product_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [pwi_pkg::DATA_W-1:0] drive_q;
	logic                              clamped_q;

	logic signed [pwi_pkg::DIFF_W-1:0] err_w;
	logic signed [pwi_pkg::DIFF_W-1:0] aerr;
	logic signed [pwi_pkg::DIFF_W-1:0] isum_w;
	logic signed [pwi_pkg::DIFF_W-1:0] diff;
	logic signed [pwi_pkg::DIFF_W-1:0] diff_abs;
	logic                              in_win;
	logic                              sign_flip;
	logic signed [pwi_pkg::DATA_W-1:0] isum_sat;
	logic signed [pwi_pkg::DATA_W-1:0] isum_sel;
	logic signed [pwi_pkg::DATA_W-1:0] lim;
	logic signed [pwi_pkg::DATA_W-1:0] nlim;
	logic signed [pwi_pkg::DATA_W-1:0] integ_nxt;
	logic [pwi_pkg::MAG_W-1:0]         quo;
	logic signed [pwi_pkg::DATA_W-1:0] deriv_nxt;
	logic signed [pwi_pkg::DATA_W-1:0] mul_a;
	logic signed [pwi_pkg::ERR_W-1:0]  mul_b;
	logic signed [ACC_W-1:0]           lo_w;
	logic signed [ACC_W-1:0]           hi_w;
	logic signed [ACC_W-1:0]           clip_lo;
	logic signed [ACC_W-1:0]           clip;
	logic                              div_busy;

	always_comb begin
		err_w    = pwi_pkg::DIFF_W'(err_q);
		aerr     = err_q[pwi_pkg::ERR_W-1] ? -err_w : err_w;
		in_win   = aerr <= $signed({3'b000, regs.integral_window});
		isum_w   = pwi_pkg::DIFF_W'(integ_q) + err_w;
		if (isum_w > pwi_pkg::DIFF_W'(pwi_pkg::S32_MAX)) begin
			isum_sat = pwi_pkg::S32_MAX;
		end else if (isum_w < pwi_pkg::DIFF_W'(pwi_pkg::S32_MIN)) begin
			isum_sat = pwi_pkg::S32_MIN;
		end else begin
			isum_sat = isum_w[pwi_pkg::DATA_W-1:0];
		end
		sign_flip = RESET_ON_CROSS &&
			((err_q[pwi_pkg::ERR_W-1] != last_err_q[pwi_pkg::ERR_W-1]) ||
			 ((err_q == '0) != (last_err_q == '0)));
		if (sign_flip) begin
			isum_sel = '0;
		end else if (in_win) begin
			isum_sel = isum_sat;
		end else begin
			isum_sel = integ_q;
		end
		lim  = $signed({1'b0, regs.integral_limit});
		nlim = -lim;
		if (isum_sel > lim) begin
			integ_nxt = lim;
		end else if (isum_sel < nlim) begin
			integ_nxt = nlim;
		end else begin
			integ_nxt = isum_sel;
		end
		diff     = err_w - pwi_pkg::DIFF_W'(last_err_q);
		diff_abs = diff[pwi_pkg::DIFF_W-1] ? -diff : diff;
	end

	pwi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.update),
		.dividend (diff_abs[pwi_pkg::MAG_W-1:0]),
		.divisor  (dt_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign status.div_busy = div_busy;

	always_comb begin
		if (dt_q == '0) begin
			deriv_nxt = '0;
		end else if (!neg_q) begin
			deriv_nxt = (quo[pwi_pkg::MAG_W-1:pwi_pkg::DATA_W-1] != '0) ?
				pwi_pkg::S32_MAX : $signed(quo[pwi_pkg::DATA_W-1:0]);
		end else if (quo[pwi_pkg::MAG_W-1] ||
			(quo[pwi_pkg::DATA_W-1] && (quo[pwi_pkg::DATA_W-2:0] != '0))) begin
			deriv_nxt = pwi_pkg::S32_MIN;
		end else begin
			deriv_nxt = -$signed(quo[pwi_pkg::DATA_W-1:0]);
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			pwi_pkg::MUL_P: begin
				mul_a = regs.gain_p;
				mul_b = err_q;
			end
			pwi_pkg::MUL_I: begin
				mul_a = regs.gain_i;
				mul_b = pwi_pkg::ERR_W'(integ_q);
			end
			pwi_pkg::MUL_D: begin
				mul_a = regs.gain_d;
				mul_b = pwi_pkg::ERR_W'(deriv_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		lo_w    = ACC_W'(regs.output_lower);
		hi_w    = ACC_W'(regs.output_upper);
		clip_lo = (acc_q < lo_w) ? lo_w : acc_q;
		clip    = (clip_lo > hi_w) ? hi_w : clip_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			integ_q    <= '0;
		end else if (cmd.update) begin
			last_err_q <= err_q;
			integ_q    <= integ_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= pwi_pkg::ERR_W'(setpoint) - pwi_pkg::ERR_W'(measurement);
			dt_q  <= elapsed_ms;
			acc_q <= settled ? '0 : ACC_W'(regs.feed_forward);
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + ACC_W'(product_q >>> FRAC_BITS);
		end
		if (cmd.update) begin
			neg_q <= diff[pwi_pkg::DIFF_W-1];
		end
		if (cmd.deriv_cap) begin
			deriv_q <= deriv_nxt;
		end
		if (cmd.mul_en) begin
			product_q <= mul_a * mul_b;
		end
		if (cmd.out_load) begin
			drive_q   <= clip[pwi_pkg::DATA_W-1:0];
			clamped_q <= clip != acc_q;
		end
	end

	assign drive   = drive_q;
	assign clamped = clamped_q;

endmodule

FILE: design/pwi_ctrl.sv
// Controller state machine sequencing the datapath and the output register.
`timescale 1ns / 1ps

module pwi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_settled,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	input  pwi_pkg::status_t status,
	output pwi_pkg::cmd_t    cmd
);

	pwi_pkg::state_t state_q;
	pwi_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pwi_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = in_settled ? pwi_pkg::ST_DONE : pwi_pkg::ST_ERR;
				end
			end
			pwi_pkg::ST_ERR:   state_d = pwi_pkg::ST_MUL_I;
			pwi_pkg::ST_MUL_I: state_d = pwi_pkg::ST_ACC_I;
			pwi_pkg::ST_ACC_I: state_d = pwi_pkg::ST_DIV_WAIT;
			pwi_pkg::ST_DIV_WAIT: begin
				if (!status.div_busy) begin
					state_d = pwi_pkg::ST_DERIV;
				end
			end
			pwi_pkg::ST_DERIV: state_d = pwi_pkg::ST_MUL_D;
			pwi_pkg::ST_MUL_D: state_d = pwi_pkg::ST_ACC_D;
			pwi_pkg::ST_ACC_D: state_d = pwi_pkg::ST_DONE;
			pwi_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pwi_pkg::ST_IDLE;
				end
			end
			default: state_d = pwi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = pwi_pkg::MUL_P;
		in_ready     = 1'b0;
		case (state_q)
			pwi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			pwi_pkg::ST_ERR: begin
				cmd.update  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pwi_pkg::MUL_P;
			end
			pwi_pkg::ST_MUL_I: begin
				cmd.acc_en  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pwi_pkg::MUL_I;
			end
			pwi_pkg::ST_ACC_I: cmd.acc_en = 1'b1;
			pwi_pkg::ST_DIV_WAIT: begin
			end
			pwi_pkg::ST_DERIV: cmd.deriv_cap = 1'b1;
			pwi_pkg::ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pwi_pkg::MUL_D;
			end
			pwi_pkg::ST_ACC_D: cmd.acc_en = 1'b1;
			pwi_pkg::ST_DONE: cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pwi_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/pid_controller_windowed_integral.sv
// Top level of the PID controller with windowed integral and clamped drive output.
// A request steps through error, integral, divider wait, derivative and output states;
// a settled item goes straight to output. A new request is taken only once the last one
// is in the output register; the 33-step serial divider for the derivative sets the rate.
// A new request is taken while the previous response still waits in the output register.
// Reset (arst_n low): integral and last error clear, registers return to their defaults.
`timescale 1ns / 1ps

module pid_controller_windowed_integral #(
	parameter int FRAC_BITS      = 16,
	parameter bit RESET_ON_CROSS = 1'b1
) (
	input  logic     clk,
	input  logic     arst_n,
	pwi_req_if.sink  request,
	pwi_rsp_if.source response,
	pwi_cfg_if.sink  cfg
);

	pwi_pkg::cfg_t    regs;
	pwi_pkg::cmd_t    cmd;
	pwi_pkg::status_t status;

	pwi_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pwi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (request.valid),
		.in_settled (request.settled),
		.in_ready   (request.ready),
		.out_ready  (response.ready),
		.out_valid  (response.valid),
		.status     (status),
		.cmd        (cmd)
	);

	pwi_dpath #(
		.FRAC_BITS      (FRAC_BITS),
		.RESET_ON_CROSS (RESET_ON_CROSS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.regs        (regs),
		.cmd         (cmd),
		.status      (status),
		.measurement (request.measurement),
		.setpoint    (request.setpoint),
		.elapsed_ms  (request.elapsed_ms),
		.settled     (request.settled),
		.drive       (response.drive),
		.clamped     (response.clamped)
	);

endmodule

FILE: design/pwi_chk.sv
// Port-level checker for the PID controller and its bind to the top level.
`timescale 1ns / 1ps

module pwi_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic signed [pwi_pkg::DATA_W-1:0] rsp_drive,
	input logic                             rsp_clamped,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [pwi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [pwi_pkg::DATA_W-1:0]       cfg_data
);

	logic [1:0]                        pending_q;
	logic signed [pwi_pkg::DATA_W-1:0] upper_q;
	logic signed [pwi_pkg::DATA_W-1:0] lower_q;
	logic                              req_xfer;
	logic                              rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			upper_q   <= pwi_pkg::S32_MAX;
			lower_q   <= pwi_pkg::S32_MIN;
		end else begin
			pending_q <= pending_q + {1'b0, req_xfer} - {1'b0, rsp_xfer};
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pwi_pkg::REG_OUT_UPPER) begin
					upper_q <= $signed(cfg_data);
				end
				if (cfg_index == pwi_pkg::REG_OUT_LOWER) begin
					lower_q <= $signed(cfg_data);
				end
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_clamped))
		else $error("response changed while stalled");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_clamped |-> rsp_drive == upper_q || rsp_drive == lower_q)
		else $error("clamped response not at a limit");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items in flight");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without an outstanding request");

endmodule

bind pid_controller_windowed_integral pwi_chk u_pwi_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.rsp_valid   (response.valid),
	.rsp_ready   (response.ready),
	.rsp_drive   (response.drive),
	.rsp_clamped (response.clamped),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready),
	.cfg_index   (cfg.index),
	.cfg_data    (cfg.data)
);
